### hw/rtl/rfi_pkg.sv
package rfi_pkg;

	// fixed formats
	localparam int COORD_WIDTH = 24;
	localparam int FRAC_BITS   = 8;
	localparam int RAD_W       = 16;
	localparam int GAIN_W      = 16;
	localparam int GAIN_FRAC   = 8;
	localparam int VEL_W       = 32;
	localparam int CFG_W       = (COORD_WIDTH > GAIN_W) ? COORD_WIDTH : GAIN_W;
	localparam int IDX_W       = 3;

	// derived datapath widths
	localparam int D_W     = COORD_WIDTH + 1;
	localparam int MAG_W   = RAD_W + FRAC_BITS;
	localparam int CMP_W   = (D_W > MAG_W) ? D_W : MAG_W;
	localparam int SUM_W   = 2 * MAG_W + 1;
	localparam int ROOT_W  = MAG_W + 1;
	localparam int RAD2_W  = 2 * ROOT_W;
	localparam int REM_W   = ROOT_W + 2;
	localparam int NUM_W   = 2 * MAG_W;
	localparam int GM_W    = 2 * GAIN_W - 1;
	localparam int PROD_W  = MAG_W + GM_W;
	localparam int GSH     = 2 * GAIN_FRAC;
	localparam int V_W     = PROD_W - GSH;

	localparam logic [RAD_W-1:0]  RADIUS_RST = RAD_W'(300);
	localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(256);

	typedef enum logic [IDX_W-1:0] {
		REG_CENTER_X  = 3'd0,
		REG_CENTER_Y  = 3'd1,
		REG_FORCE_G   = 3'd2,
		REG_MOVE_G    = 3'd3,
		REG_RADIUS    = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [MAG_W-1:0] adx;
		logic [MAG_W-1:0] ady;
		logic             neg_x;
		logic             neg_y;
		logic             inr;
		logic             last;
	} side_t;

	typedef struct packed {
		side_t             side;
		logic [RAD2_W-1:0] rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [MAG_W-1:0] low;
		logic [MAG_W-1:0] quo;
	} ax_t;

	typedef struct packed {
		logic [MAG_W-1:0] div;
		ax_t              x;
		ax_t              y;
		logic             neg_x;
		logic             neg_y;
		logic             act;
		logic             last;
	} dv_t;

	// one restoring square root step, two radicand bits
	function automatic sq_t sq_step(sq_t s);
		logic [REM_W-1:0] remn;
		logic [REM_W-1:0] trial;
		sq_t              o;
		remn  = {s.rem[REM_W-3:0], s.rad[RAD2_W-1 -: 2]};
		trial = {s.root, 2'b01};
		o     = s;
		o.rad = {s.rad[RAD2_W-3:0], 2'b00};
		if (remn >= trial) begin
			o.rem  = remn - trial;
			o.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = remn;
			o.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

	// one restoring division step, one quotient bit
	function automatic ax_t div_step(ax_t a, logic [MAG_W-1:0] d);
		logic [MAG_W:0] r;
		ax_t            o;
		r     = {a.rem, a.low[MAG_W-1]};
		o.low = {a.low[MAG_W-2:0], 1'b0};
		if (r >= {1'b0, d}) begin
			o.rem = MAG_W'(r - {1'b0, d});
			o.quo = {a.quo[MAG_W-2:0], 1'b1};
		end else begin
			o.rem = r[MAG_W-1:0];
			o.quo = {a.quo[MAG_W-2:0], 1'b0};
		end
		return o;
	endfunction

	// signed saturation of a magnitude
	function automatic logic [VEL_W-1:0] vel_sat(logic [V_W-1:0] v, logic neg);
		logic [V_W-1:0] lim;
		lim = V_W'({1'b1, (VEL_W-1)'(0)});
		if (v == '0)
			return '0;
		if (neg) begin
			if (v > lim)
				return {1'b1, (VEL_W-1)'(0)};
			return VEL_W'(V_W'(0) - v);
		end
		if (v >= lim)
			return {1'b0, {(VEL_W-1){1'b1}}};
		return VEL_W'(v);
	endfunction

endpackage

### hw/rtl/rfi_if.sv
interface rfi_node_if import rfi_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] node_x;
	logic signed [COORD_WIDTH-1:0] node_y;
	logic                          last_node;

	modport source (output valid, node_x, node_y, last_node, input ready);
	modport sink   (input valid, node_x, node_y, last_node, output ready);
endinterface

interface rfi_vel_if import rfi_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VEL_W-1:0] vel_x;
	logic signed [VEL_W-1:0] vel_y;
	logic                    last_out;

	modport source (output valid, vel_x, vel_y, last_out, input ready);
	modport sink   (input valid, vel_x, vel_y, last_out, output ready);
endinterface

### hw/rtl/rfi_sqrt_cell.sv
module rfi_sqrt_cell import rfi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_i,
	input  sq_t  d_i,
	output logic vld_o,
	output sq_t  d_o
);

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_o <= 1'b0;
		else if (en)
			vld_o <= vld_i;
	end

	// one root bit per cell
	always_ff @(posedge clk) begin
		if (en)
			d_o <= sq_step(d_i);
	end

endmodule

### hw/rtl/rfi_div_cell.sv
module rfi_div_cell import rfi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_i,
	input  dv_t  d_i,
	output logic vld_o,
	output dv_t  d_o
);

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_o <= 1'b0;
		else if (en)
			vld_o <= vld_i;
	end

	// one quotient bit per axis per cell
	always_ff @(posedge clk) begin
		if (en) begin
			d_o.div   <= d_i.div;
			d_o.x     <= div_step(d_i.x, d_i.div);
			d_o.y     <= div_step(d_i.y, d_i.div);
			d_o.neg_x <= d_i.neg_x;
			d_o.neg_y <= d_i.neg_y;
			d_o.act   <= d_i.act;
			d_o.last  <= d_i.last;
		end
	end

endmodule

### hw/rtl/radial_falloff_impulse.sv
// throughput: one node per cycle, the whole chain stalls only when the output is held
// timing is set by the 25-cell square root chain and the 24-cell divider chain
// reset: center at 0, both gains 1.0, falloff radius 300, all pipeline valids cleared
module radial_falloff_impulse import rfi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	rfi_node_if.sink         node_req,
	rfi_vel_if.source        vel_req,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0] cfg_data
);

	logic                   adv;
	logic [COORD_WIDTH-1:0] cx_q, cy_q;
	logic [GAIN_W-1:0]      fg_q, mg_q;
	logic [RAD_W-1:0]       rad_q;
	logic [GM_W-1:0]        gmag_q;
	logic                   gneg_q;
	logic [MAG_W-1:0]       rq;
	logic [GAIN_W:0]        afg, amg;

	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [D_W-1:0]         dx_s1, dy_s1;
	logic                   last_s1;
	side_t                  side_s2;
	sq_t                    sq_s3;
	dv_t                    dv_s4;
	logic [PROD_W-1:0]      px_s5, py_s5;
	logic                   negx_s5, negy_s5, act_s5, last_s5;

	logic                   out_vld_q, last_q;
	logic [VEL_W-1:0]       vel_x_q, vel_y_q;

	logic [ROOT_W:0]        sq_vld;
	sq_t                    sq_c [ROOT_W+1];
	logic [MAG_W:0]         dv_vld;
	dv_t                    dv_c [MAG_W+1];

	// whole chain moves unless the output request is held
	assign adv            = !out_vld_q || vel_req.ready;
	assign node_req.ready = adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			fg_q  <= GAIN_ONE;
			mg_q  <= GAIN_ONE;
			rad_q <= RADIUS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CENTER_X: cx_q  <= COORD_WIDTH'(cfg_data);
				REG_CENTER_Y: cy_q  <= COORD_WIDTH'(cfg_data);
				REG_FORCE_G:  fg_q  <= GAIN_W'(cfg_data);
				REG_MOVE_G:   mg_q  <= GAIN_W'(cfg_data);
				REG_RADIUS:   rad_q <= RAD_W'(cfg_data);
				default: ;
			endcase
		end
	end

	assign rq  = MAG_W'(rad_q) << FRAC_BITS;
	assign afg = fg_q[GAIN_W-1] ? ((GAIN_W+1)'(0) - {1'b1, fg_q}) : {1'b0, fg_q};
	assign amg = mg_q[GAIN_W-1] ? ((GAIN_W+1)'(0) - {1'b1, mg_q}) : {1'b0, mg_q};

	// combined gain magnitude and sign
	always_ff @(posedge clk) begin
		gmag_q <= GM_W'(afg * amg);
		gneg_q <= fg_q[GAIN_W-1] ^ mg_q[GAIN_W-1];
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= node_req.valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= sq_vld[ROOT_W];
			vld_s5    <= dv_vld[MAG_W];
			out_vld_q <= vld_s5;
		end
	end

	// offset from the center
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1   <= D_W'({node_req.node_x[COORD_WIDTH-1], node_req.node_x}
			                - {cx_q[COORD_WIDTH-1], cx_q});
			dy_s1   <= D_W'({node_req.node_y[COORD_WIDTH-1], node_req.node_y}
			                - {cy_q[COORD_WIDTH-1], cy_q});
			last_s1 <= node_req.last_node;
		end
	end

	// magnitudes and box test against the radius
	logic [D_W-1:0] adx_c, ady_c;
	logic           inr_c;
	assign adx_c = dx_s1[D_W-1] ? (D_W'(0) - dx_s1) : dx_s1;
	assign ady_c = dy_s1[D_W-1] ? (D_W'(0) - dy_s1) : dy_s1;
	assign inr_c = ((dx_s1 != '0) || (dy_s1 != '0))
	               && (CMP_W'(adx_c) < CMP_W'(rq)) && (CMP_W'(ady_c) < CMP_W'(rq));

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2.adx   <= inr_c ? MAG_W'(adx_c) : '0;
			side_s2.ady   <= inr_c ? MAG_W'(ady_c) : '0;
			side_s2.neg_x <= dx_s1[D_W-1];
			side_s2.neg_y <= dy_s1[D_W-1];
			side_s2.inr   <= inr_c;
			side_s2.last  <= last_s1;
		end
	end

	// squared distance
	logic [SUM_W-1:0] ex_c, ey_c, sum_c;
	assign ex_c  = SUM_W'(side_s2.adx);
	assign ey_c  = SUM_W'(side_s2.ady);
	assign sum_c = SUM_W'(ex_c * ex_c) + SUM_W'(ey_c * ey_c);

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s3.side <= side_s2;
			sq_s3.rad  <= RAD2_W'(sum_c);
			sq_s3.rem  <= '0;
			sq_s3.root <= '0;
		end
	end

	// square root chain
	assign sq_vld[0] = vld_s3;
	assign sq_c[0]   = sq_s3;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		rfi_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_i  (sq_vld[i]),
			.d_i    (sq_c[i]),
			.vld_o  (sq_vld[i+1]),
			.d_o    (sq_c[i+1])
		);
	end

	// falloff and numerators
	sq_t              sq_end;
	logic             act_c;
	logic [MAG_W-1:0] fall_c;
	logic [NUM_W-1:0] nx_c, ny_c, f_ext;
	assign sq_end = sq_c[ROOT_W];
	assign act_c  = sq_end.side.inr && (sq_end.root != '0) && (sq_end.root < ROOT_W'(rq));
	assign fall_c = MAG_W'(ROOT_W'(rq) - sq_end.root);
	assign f_ext  = act_c ? NUM_W'(fall_c) : '0;
	assign nx_c   = NUM_W'(NUM_W'(sq_end.side.adx) * f_ext);
	assign ny_c   = NUM_W'(NUM_W'(sq_end.side.ady) * f_ext);

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s4.div   <= act_c ? MAG_W'(sq_end.root) : MAG_W'(1);
			dv_s4.x.rem <= nx_c[NUM_W-1:MAG_W];
			dv_s4.x.low <= nx_c[MAG_W-1:0];
			dv_s4.x.quo <= '0;
			dv_s4.y.rem <= ny_c[NUM_W-1:MAG_W];
			dv_s4.y.low <= ny_c[MAG_W-1:0];
			dv_s4.y.quo <= '0;
			dv_s4.neg_x <= sq_end.side.neg_x;
			dv_s4.neg_y <= sq_end.side.neg_y;
			dv_s4.act   <= act_c;
			dv_s4.last  <= sq_end.side.last;
		end
	end

	// divider chain
	assign dv_vld[0] = vld_s4;
	assign dv_c[0]   = dv_s4;

	for (genvar i = 0; i < MAG_W; i++) begin : g_div
		rfi_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_i  (dv_vld[i]),
			.d_i    (dv_c[i]),
			.vld_o  (dv_vld[i+1]),
			.d_o    (dv_c[i+1])
		);
	end

	// gain multiply
	dv_t dv_end;
	assign dv_end = dv_c[MAG_W];

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s5   <= PROD_W'(PROD_W'(dv_end.x.quo) * PROD_W'(gmag_q));
			py_s5   <= PROD_W'(PROD_W'(dv_end.y.quo) * PROD_W'(gmag_q));
			negx_s5 <= dv_end.neg_x ^ gneg_q;
			negy_s5 <= dv_end.neg_y ^ gneg_q;
			act_s5  <= dv_end.act;
			last_s5 <= dv_end.last;
		end
	end

	// scale, saturate, output register
	always_ff @(posedge clk) begin
		if (adv) begin
			vel_x_q <= act_s5 ? vel_sat(px_s5[PROD_W-1:GSH], negx_s5) : '0;
			vel_y_q <= act_s5 ? vel_sat(py_s5[PROD_W-1:GSH], negy_s5) : '0;
			last_q  <= last_s5;
		end
	end

	assign vel_req.valid    = out_vld_q;
	assign vel_req.vel_x    = vel_x_q;
	assign vel_req.vel_y    = vel_y_q;
	assign vel_req.last_out = last_q;

	// checks
	a_div_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s4) |=> dv_vld[1])
		else $error("request lost entering divider chain");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(vld_s5) && $stable(sq_vld[ROOT_W])))
		else $error("pipeline moved while output held");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s5 && !act_s5) |=> (vel_x_q == '0 && vel_y_q == '0))
		else $error("inactive node gave nonzero velocity");

endmodule

### sim/radial_falloff_impulse_test.sv
`timescale 1ns / 100ps

module radial_falloff_impulse_test;
	import rfi_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(5);
	localparam int DRAIN_CYCLES = 70;
	localparam int STALL_LIMIT  = 3000;
	localparam int PHASE_ITEMS  = 137;

	typedef struct {
		logic [COORD_WIDTH-1:0] x;
		logic [COORD_WIDTH-1:0] y;
		logic                   last;
		bit                     fixed;
		logic [VEL_W-1:0]       vx;
		logic [VEL_W-1:0]       vy;
	} node_row_t;

	typedef struct {
		logic [VEL_W-1:0] vx;
		logic [VEL_W-1:0] vy;
		logic             last;
	} vel_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	rfi_node_if node_bus ();
	rfi_vel_if  vel_bus ();

	radial_falloff_impulse dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.node_req (node_bus),
		.vel_req  (vel_bus),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// shadow copy of the configuration
	longint ctr_x, ctr_y, f_gain, m_gain, radius;

	node_row_t pending_nodes[$];
	vel_t      expected_vels[$];
	int        errors;
	int        idle_pct;
	int        stall_pct;
	int        quiet_cycles;

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// integer square root, floor
	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// one axis of the push, saturated to the velocity width
	function automatic logic [VEL_W-1:0] axis_push(longint d, longint unsigned fall,
			longint unsigned mag, longint unsigned gmag, bit gneg);
		longint unsigned ad, t, v;
		bit neg;
		ad = (d < 0) ? -d : d;
		t = (ad * fall) / mag;
		v = (t * gmag) >> (2 * GAIN_FRAC);
		neg = (d < 0) != gneg;
		if (v == 0)
			return '0;
		if (neg) begin
			if (v > 64'h8000_0000)
				v = 64'h8000_0000;
			return VEL_W'(-v);
		end
		if (v > 64'h7FFF_FFFF)
			v = 64'h7FFF_FFFF;
		return VEL_W'(v);
	endfunction

	function automatic vel_t predict_push(logic [COORD_WIDTH-1:0] nx,
			logic [COORD_WIDTH-1:0] ny, logic last);
		longint dx, dy;
		longint unsigned rq, adx, ady, mag, gmag;
		bit gneg;
		vel_t r;
		dx = longint'($signed(nx)) - ctr_x;
		dy = longint'($signed(ny)) - ctr_y;
		rq = longint'(radius) << FRAC_BITS;
		adx = (dx < 0) ? -dx : dx;
		ady = (dy < 0) ? -dy : dy;
		r.vx = '0;
		r.vy = '0;
		r.last = last;
		if ((adx != 0 || ady != 0) && adx < rq && ady < rq) begin
			mag = root_floor(adx * adx + ady * ady);
			if (mag < rq && mag != 0) begin
				gmag = ((f_gain < 0) ? -f_gain : f_gain) * ((m_gain < 0) ? -m_gain : m_gain);
				gneg = (f_gain < 0) != (m_gain < 0);
				r.vx = axis_push(dx, rq - mag, mag, gmag, gneg);
				r.vy = axis_push(dy, rq - mag, mag, gmag, gneg);
			end
		end
		return r;
	endfunction

	// register write, shadow updated alongside
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CENTER_X: ctr_x  = longint'($signed(val[COORD_WIDTH-1:0]));
			REG_CENTER_Y: ctr_y  = longint'($signed(val[COORD_WIDTH-1:0]));
			REG_FORCE_G:  f_gain = longint'($signed(val[GAIN_W-1:0]));
			REG_MOVE_G:   m_gain = longint'($signed(val[GAIN_W-1:0]));
			REG_RADIUS:   radius = longint'(val[RAD_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic write_all(logic [CFG_W-1:0] cx, logic [CFG_W-1:0] cy,
			logic [CFG_W-1:0] fg, logic [CFG_W-1:0] mg, logic [CFG_W-1:0] rad);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_FORCE_G, fg);
		write_reg(REG_MOVE_G, mg);
		write_reg(REG_RADIUS, rad);
		write_reg(REG_UNUSED, CFG_W'($urandom));
	endtask

	// one node request, held until accepted
	task automatic push_node(node_row_t row);
		while ($urandom_range(99) < idle_pct) begin
			node_bus.valid <= 1'b0;
			@(posedge clk);
		end
		pending_nodes = {pending_nodes, row};
		node_bus.valid     <= 1'b1;
		node_bus.node_x    <= row.x;
		node_bus.node_y    <= row.y;
		node_bus.last_node <= row.last;
		@(posedge clk);
		while (!node_bus.ready)
			@(posedge clk);
	endtask

	task automatic drain;
		node_bus.valid <= 1'b0;
		while (expected_vels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// node near the centre most of the time, anywhere otherwise
	function automatic node_row_t random_node();
		node_row_t row;
		longint span;
		span = (radius << FRAC_BITS) + 64;
		if ($urandom_range(3) == 0)
			span = 512;
		if ($urandom_range(4) == 0) begin
			row.x = COORD_WIDTH'($urandom);
			row.y = COORD_WIDTH'($urandom);
		end else begin
			row.x = COORD_WIDTH'(ctr_x + longint'($urandom_range(2 * span)) - span);
			row.y = COORD_WIDTH'(ctr_y + longint'($urandom_range(2 * span)) - span);
		end
		row.last = 1'($urandom_range(1));
		row.fixed = 0;
		return row;
	endfunction

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_bus.ready <= 1'b0;
		end else begin
			vel_bus.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// prediction on node acceptance, compare on velocity acceptance
	always @(posedge clk) begin
		node_row_t row;
		vel_t pv, ev;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (node_bus.valid && node_bus.ready) begin
				moved = 1'b1;
				row = pending_nodes.pop_front();
				pv = predict_push(node_bus.node_x, node_bus.node_y, node_bus.last_node);
				if (row.fixed) begin
					pv.vx = row.vx;
					pv.vy = row.vy;
				end
				expected_vels = {expected_vels, pv};
			end
			if (vel_bus.valid && vel_bus.ready) begin
				moved = 1'b1;
				if (expected_vels.size() == 0) begin
					$display("%t: unexpected velocity request vx=%h vy=%h last=%b", $realtime,
						vel_bus.vel_x, vel_bus.vel_y, vel_bus.last_out);
					errors++;
				end else begin
					ev = expected_vels.pop_front();
					if (ev.vx !== vel_bus.vel_x || ev.vy !== vel_bus.vel_y
							|| ev.last !== vel_bus.last_out) begin
						$display("%t: expected vx=%h vy=%h last=%b, got vx=%h vy=%h last=%b",
							$realtime, ev.vx, ev.vy, ev.last,
							vel_bus.vel_x, vel_bus.vel_y, vel_bus.last_out);
						errors++;
					end
				end
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		node_row_t dir_rows[$];
		node_row_t row;
		errors = 0;
		quiet_cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		ctr_x = 0;
		ctr_y = 0;
		f_gain = 256;
		m_gain = 256;
		radius = 300;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		node_bus.valid = 1'b0;
		node_bus.node_x = '0;
		node_bus.node_y = '0;
		node_bus.last_node = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under reset settings
		dir_rows = '{
			'{24'sd0, 24'sd0, 1'b0, 1, 32'sd0, 32'sd0},
			'{24'sd76800, 24'sd0, 1'b1, 1, 32'sd0, 32'sd0},
			'{24'h7FFFFF, 24'h800000, 1'b0, 1, 32'sd0, 32'sd0},
			'{24'h800000, 24'h7FFFFF, 1'b1, 1, 32'sd0, 32'sd0},
			'{24'sd25600, 24'sd0, 1'b0, 1, 32'sd51200, 32'sd0},
			'{-24'sd25600, 24'sd0, 1'b1, 1, -32'sd51200, 32'sd0},
			'{24'sd0, -24'sd25600, 1'b0, 1, 32'sd0, -32'sd51200},
			'{24'sd1, 24'sd0, 1'b0, 0, '0, '0},
			'{24'sd76799, 24'sd0, 1'b0, 0, '0, '0},
			'{24'sd54305, 24'sd54305, 1'b1, 0, '0, '0},
			'{24'sd54306, -24'sd54306, 1'b0, 0, '0, '0},
			'{-24'sd300, 24'sd1000, 1'b1, 0, '0, '0},
			'{24'sd12345, -24'sd6789, 1'b0, 0, '0, '0}
		};
		foreach (dir_rows[i])
			push_node(dir_rows[i]);
		drain();

		// extreme settings with a few directed nodes
		write_all(24'h7FFFFF, 24'h800000, 24'h008000, 24'h008000, 24'h00FFFF);
		row = '{24'h7FFFFF, 24'h800000, 1'b0, 1, 32'sd0, 32'sd0};
		push_node(row);
		row = '{24'h7F0000, 24'h800000, 1'b1, 0, '0, '0};
		push_node(row);
		row = '{24'h7FFFFF, 24'h810000, 1'b0, 0, '0, '0};
		push_node(row);
		drain();

		// random phases, each with its own setting; the idling mix repeats every four phases
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 69; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 69; end
				default: begin idle_pct = 25; stall_pct = 25; end
			endcase
			case (p)
				0: write_all(24'h000000, 24'h000000, 24'h000100, 24'h000100, 24'h00012C);
				1: write_all(24'h7FFFFF, 24'h800000, 24'h008000, 24'h008000, 24'h00FFFF);
				2: write_all(24'h123456, 24'hFEDCBA, 24'h007FFF, 24'h008000, 24'h000000);
				3: write_all(24'h800000, 24'h7FFFFF, 24'h007FFF, 24'h007FFF, 24'h000001);
				default: write_all(CFG_W'($urandom), CFG_W'($urandom),
					CFG_W'($urandom), CFG_W'($urandom),
					CFG_W'({CFG_W'($urandom) >> 16, 8'h00} | CFG_W'($urandom_range(2000))));
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				push_node(random_node());
			drain();
		end

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/rfi_pkg.sv
hw/rtl/rfi_if.sv
hw/rtl/rfi_sqrt_cell.sv
hw/rtl/rfi_div_cell.sv
hw/rtl/radial_falloff_impulse.sv
sim/radial_falloff_impulse_test.sv
